// ----- hw/rtl/dwq_pkg.sv -----
// Shared types and constants for the deduplicating work queue.
// Holds the result kind codes, the action codes and the controller/datapath
// command and status structs. No dependencies.
package dwq_pkg;

	localparam int unsigned ENTRY_W = 8;   // width of an offered entry index
	localparam int unsigned DRAIN_W = 6;   // width of a drained index
	localparam int unsigned POP_W   = 7;   // width of the population register
	localparam int unsigned KIND_W  = 3;   // width of the result kind
	localparam int unsigned TDATA_W = 8;   // both tdata buses, padded to a byte

	localparam logic [POP_W-1:0] POP_RESET = 7'd64;

	typedef enum logic [KIND_W-1:0] {
		KIND_ENQUEUED     = 3'd0,
		KIND_DUPLICATE    = 3'd1,
		KIND_OUT_OF_RANGE = 3'd2,
		KIND_DRAINED      = 3'd3,
		KIND_EMPTY        = 3'd4
	} dwq_kind_t;

	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_DRAIN   = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic enq;          // evaluate the offered index and load its result
		logic drain_empty;  // load the empty-queue result
		logic rd;           // read the head entry, advance the read pointer
		logic emit;         // load the drained entry and clear its bit
	} dwq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic occ_zero;     // queue holds no entries
		logic out_free;     // output register can take a beat this cycle
	} dwq_sts_t;

endpackage

// ----- hw/rtl/dwq_ctrl.sv -----
// Controller state machine of the deduplicating work queue.
// Sequences enqueue, empty drain and the per-entry drain loop.
// Depends on dwq_pkg.
module dwq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_action,
	output logic            in_ready,
	input  dwq_pkg::dwq_sts_t sts,
	output dwq_pkg::dwq_cmd_t cmd
);
	import dwq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					if (in_action == ACT_ENQUEUE) begin
						cmd.enq = 1'b1;
					end else if (sts.occ_zero) begin
						cmd.drain_empty = 1'b1;
					end else begin
						state_nxt = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.rd    = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = sts.occ_zero ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- hw/rtl/dwq_datapath.sv -----
// Datapath of the deduplicating work queue: population register, queue
// memory, pointers, occupancy, membership bitmap and the output register.
// Depends on dwq_pkg.
module dwq_datapath #(
	parameter int unsigned MAX_ENTRIES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [dwq_pkg::POP_W-1:0]    cfg_wr_data,
	input  logic [dwq_pkg::ENTRY_W-1:0]  entry_index,
	input  dwq_pkg::dwq_cmd_t            cmd,
	output dwq_pkg::dwq_sts_t            sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dwq_pkg::KIND_W-1:0]   out_kind,
	output logic [dwq_pkg::DRAIN_W-1:0]  out_index,
	output logic                         out_last
);
	import dwq_pkg::*;

	localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned OCC_W = $clog2(MAX_ENTRIES + 1);
	localparam logic [IDX_W-1:0] PTR_LAST = IDX_W'(MAX_ENTRIES - 1);
	localparam logic [POP_W-1:0] POP_CAP  = POP_W'(MAX_ENTRIES);

	logic [POP_W-1:0]     pop_q;
	logic [DRAIN_W-1:0]   mem_q [MAX_ENTRIES];
	logic [DRAIN_W-1:0]   rd_data_q;
	logic [IDX_W-1:0]     rptr_q;
	logic [IDX_W-1:0]     wptr_q;
	logic [OCC_W-1:0]     occ_q;
	logic [MAX_ENTRIES-1:0] queued_q;

	logic                 out_valid_q;
	dwq_kind_t            kind_q;
	logic [DRAIN_W-1:0]   index_q;
	logic                 last_q;

	logic [POP_W-1:0]     limit;
	logic                 in_range;
	logic                 dup;
	logic                 enq_ok;
	logic                 load;
	dwq_kind_t            load_kind;
	logic [DRAIN_W-1:0]   load_index;

	// An index is valid only below the population, capped at capacity.
	assign limit    = (pop_q > POP_CAP) ? POP_CAP : pop_q;
	assign in_range = entry_index < {1'b0, limit};
	assign dup      = queued_q[entry_index[IDX_W-1:0]];
	assign enq_ok   = cmd.enq && in_range && !dup;

	assign sts.occ_zero = (occ_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		load       = cmd.enq || cmd.drain_empty || cmd.emit;
		load_index = '0;
		load_kind  = KIND_EMPTY;
		if (cmd.enq) begin
			if (!in_range) begin
				load_kind = KIND_OUT_OF_RANGE;
			end else if (dup) begin
				load_kind = KIND_DUPLICATE;
			end else begin
				load_kind = KIND_ENQUEUED;
			end
		end else if (cmd.emit) begin
			load_kind  = KIND_DRAINED;
			load_index = rd_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q <= POP_RESET;
		end else if (cfg_wr_en) begin
			pop_q <= cfg_wr_data;
		end
	end

	// Queue memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (enq_ok) begin
			mem_q[wptr_q] <= entry_index[DRAIN_W-1:0];
		end
		if (cmd.rd) begin
			rd_data_q <= mem_q[rptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q   <= '0;
			wptr_q   <= '0;
			occ_q    <= '0;
			queued_q <= '0;
		end else begin
			if (enq_ok) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
				occ_q  <= occ_q + 1'b1;
				queued_q[entry_index[IDX_W-1:0]] <= 1'b1;
			end
			if (cmd.rd) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
				occ_q  <= occ_q - 1'b1;
			end
			if (cmd.emit) begin
				queued_q[rd_data_q[IDX_W-1:0]] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= load_kind;
			index_q <= load_index;
			// Only the final drained entry closes a drain; occupancy has
			// already been decremented by the read that fetched it.
			last_q  <= cmd.emit ? (occ_q == '0) : 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_index = index_q;
	assign out_last  = last_q;

endmodule

// ----- hw/rtl/dedup_work_queue.sv -----
// Top level of the deduplicating work queue.
// Joins the controller (dwq_ctrl) and the datapath (dwq_datapath).
// Depends on dwq_pkg.

// The block keeps a FIFO of entry indices that never holds the same index
// twice. An enqueue beat (s_tuser = 0) offers s_tdata as an index and always
// yields exactly one result beat with tlast set: enqueued, already queued, or
// out of range when the index is not below the population size (capped at
// MAX_ENTRIES). A drain beat (s_tuser = 1) yields one result beat per queued
// index in arrival order, tlast on the final one, and clears each membership
// bit as the index leaves; an empty queue yields a single empty result. After
// an enqueue the next beat may follow at once while the output is taken. In a
// drain each entry is first read from the queue memory, whose read data is
// registered, and then loaded into the output register, which waits while
// the output is not free. No input beat is taken while a drain runs. The
// membership bitmap resets at once, so there is no clearing pass after reset.
// The population register may be rewritten only while the block is idle;
// entries already queued stay queued after it shrinks.
module dedup_work_queue #(
	parameter int unsigned MAX_ENTRIES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,

	// Population size register: written on any cycle with cfg_wr_en high.
	input  logic                         cfg_wr_en,
	input  logic [dwq_pkg::POP_W-1:0]    cfg_wr_data,

	// Request stream.
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [dwq_pkg::TDATA_W-1:0]  s_tdata,   // [7:0] entry_index
	input  logic                         s_tuser,   // [0] action

	// Result stream.
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [dwq_pkg::TDATA_W-1:0]  m_tdata,   // [5:0] drained_index, [7:6] zero
	output logic [dwq_pkg::KIND_W-1:0]   m_tuser,   // [2:0] result_kind
	output logic                         m_tlast
);
	import dwq_pkg::*;

	dwq_cmd_t            cmd;
	dwq_sts_t            sts;
	logic [DRAIN_W-1:0]  out_index;

	// The controller owns the request handshake and the drain loop.
	dwq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (s_tuser),
		.in_ready  (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds all queue state and the single output register.
	// A waiting result holds off the next request until the cycle in which
	// that result is taken.
	dwq_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.entry_index (s_tdata),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_kind    (m_tuser),
		.out_index   (out_index),
		.out_last    (m_tlast)
	);

	// The drained index sits in the low bits; the rest of the byte is zero.
	assign m_tdata = {{(TDATA_W - DRAIN_W){1'b0}}, out_index};

endmodule
